>>> rtl/tcp_pkg.sv
// tcp_pkg: shared types and constants for the timecode line parser
// holds result status codes, satellite codes, character codes and the record summary struct
// no dependencies
package tcp_pkg;

  localparam int CharW = 7;

  // result status codes
  localparam logic [2:0] ST_TIME_OK   = 3'd0;
  localparam logic [2:0] ST_POSITION  = 3'd1;
  localparam logic [2:0] ST_BAD_REPLY = 3'd2;
  localparam logic [2:0] ST_BAD_DATE  = 3'd3;
  localparam logic [2:0] ST_BAD_TIME  = 3'd4;

  // stored satellite codes
  localparam logic [1:0] SAT_NONE    = 2'd0;
  localparam logic [1:0] SAT_WEST    = 2'd1;
  localparam logic [1:0] SAT_EAST    = 2'd2;
  localparam logic [1:0] SAT_STANDBY = 2'd3;

  // record lengths and field limits
  localparam int TimeLen   = 13;
  localparam int PosLen    = 21;
  localparam int DayMax    = 366;
  localparam int HourMax   = 23;
  localparam int MinSecMax = 59;

  // character codes
  localparam logic [CharW-1:0] CH_SPACE = 7'h20;
  localparam logic [CharW-1:0] CH_STAR  = 7'h2a;
  localparam logic [CharW-1:0] CH_PLUS  = 7'h2b;
  localparam logic [CharW-1:0] CH_MINUS = 7'h2d;
  localparam logic [CharW-1:0] CH_DOT   = 7'h2e;
  localparam logic [CharW-1:0] CH_ZERO  = 7'h30;
  localparam logic [CharW-1:0] CH_ONE   = 7'h31;
  localparam logic [CharW-1:0] CH_TWO   = 7'h32;
  localparam logic [CharW-1:0] CH_THREE = 7'h33;
  localparam logic [CharW-1:0] CH_SEVEN = 7'h37;
  localparam logic [CharW-1:0] CH_NINE  = 7'h39;
  localparam logic [CharW-1:0] CH_COLON = 7'h3a;

  // summary of the record as it stands after the current beat
  typedef struct packed {
    logic             nonempty;
    logic             time_form;
    logic             pos_form;
    logic [9:0]       day;
    logic [6:0]       hour;
    logic [6:0]       minute;
    logic [6:0]       second;
    logic [CharW-1:0] quality;
    logic [CharW-1:0] first_ch;
    logic [CharW-1:0] second_ch;
  } rec_t;

endpackage

>>> rtl/tcp_scan.sv
// tcp_scan: per-record character checker and digit accumulator
// keeps the record state and reports the record summary including the current beat
// depends on tcp_pkg
module tcp_scan import tcp_pkg::*; #(
  parameter int RECORD_LIMIT = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [CharW-1:0] ch,
  input  logic             last,
  output rec_t             rec
);

  localparam int CW = $clog2(RECORD_LIMIT + 1);

  logic [CW-1:0]    char_count, char_count_next;
  logic [9:0]       day_accum, day_accum_next;
  logic [6:0]       hour_accum, hour_accum_next;
  logic [6:0]       minute_accum, minute_accum_next;
  logic [6:0]       second_accum, second_accum_next;
  logic [CharW-1:0] quality_char, quality_char_next;
  logic             short_form_ok, short_form_ok_next;
  logic             long_form_ok, long_form_ok_next;
  logic [CharW-1:0] first_char, first_char_next;
  logic [CharW-1:0] second_char, second_char_next;

  logic       keep, dig, sgn;
  logic [3:0] dval;
  logic [13:0] day_mul;
  logic [10:0] hour_mul, minute_mul, second_mul;

  assign keep = (ch >= CH_SPACE) && (char_count < CW'(RECORD_LIMIT));
  assign dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign sgn  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign dval = 4'(ch - CH_ZERO);

  // acc*10 + digit as shifts and adds
  assign day_mul    = ({4'd0, day_accum} << 3) + ({4'd0, day_accum} << 1) + 14'(dval);
  assign hour_mul   = ({4'd0, hour_accum} << 3) + ({4'd0, hour_accum} << 1) + 11'(dval);
  assign minute_mul = ({4'd0, minute_accum} << 3) + ({4'd0, minute_accum} << 1)
                      + 11'(dval);
  assign second_mul = ({4'd0, second_accum} << 3) + ({4'd0, second_accum} << 1)
                      + 11'(dval);

  always_comb begin
    char_count_next    = char_count;
    day_accum_next     = day_accum;
    hour_accum_next    = hour_accum;
    minute_accum_next  = minute_accum;
    second_accum_next  = second_accum;
    quality_char_next  = quality_char;
    short_form_ok_next = short_form_ok;
    long_form_ok_next  = long_form_ok;
    first_char_next    = first_char;
    second_char_next   = second_char;
    if (keep) begin
      char_count_next = char_count + CW'(1);
      // time record pattern
      if (char_count < CW'(12)) begin
        if (char_count == CW'(3) || char_count == CW'(6) || char_count == CW'(9)) begin
          if (ch != CH_COLON) short_form_ok_next = 1'b0;
        end else if (!dig) begin
          short_form_ok_next = 1'b0;
        end
      end
      if (char_count <= CW'(2)) begin
        if (dig) day_accum_next = day_mul[9:0];
      end else if (char_count == CW'(4) || char_count == CW'(5)) begin
        if (dig) hour_accum_next = hour_mul[6:0];
      end else if (char_count == CW'(7) || char_count == CW'(8)) begin
        if (dig) minute_accum_next = minute_mul[6:0];
      end else if (char_count == CW'(10) || char_count == CW'(11)) begin
        if (dig) second_accum_next = second_mul[6:0];
      end else if (char_count == CW'(12)) begin
        quality_char_next = ch;
      end
      // position record pattern
      if (char_count < CW'(PosLen)) begin
        if (char_count == CW'(3) || char_count == CW'(10) || char_count == CW'(19)) begin
          if (ch != CH_DOT) long_form_ok_next = 1'b0;
        end else if (char_count == CW'(8) || char_count == CW'(15)) begin
          if (!sgn) long_form_ok_next = 1'b0;
        end else if (!dig) begin
          long_form_ok_next = 1'b0;
        end
      end
      if (char_count == CW'(0)) first_char_next = ch;
      if (char_count == CW'(1)) second_char_next = ch;
    end
  end

  always_comb begin
    rec.nonempty  = char_count_next != CW'(0);
    rec.time_form = (char_count_next == CW'(TimeLen)) && short_form_ok_next;
    rec.pos_form  = (char_count_next == CW'(PosLen)) && long_form_ok_next;
    rec.day       = day_accum_next;
    rec.hour      = hour_accum_next;
    rec.minute    = minute_accum_next;
    rec.second    = second_accum_next;
    rec.quality   = quality_char_next;
    rec.first_ch  = first_char_next;
    rec.second_ch = second_char_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (go && last)) begin
      char_count    <= '0;
      day_accum     <= '0;
      hour_accum    <= '0;
      minute_accum  <= '0;
      second_accum  <= '0;
      quality_char  <= '0;
      short_form_ok <= 1'b1;
      long_form_ok  <= 1'b1;
      first_char    <= '0;
      second_char   <= '0;
    end else if (go) begin
      char_count    <= char_count_next;
      day_accum     <= day_accum_next;
      hour_accum    <= hour_accum_next;
      minute_accum  <= minute_accum_next;
      second_accum  <= second_accum_next;
      quality_char  <= quality_char_next;
      short_form_ok <= short_form_ok_next;
      long_form_ok  <= long_form_ok_next;
      first_char    <= first_char_next;
      second_char   <= second_char_next;
    end
  end

endmodule

>>> rtl/timecode_line_parser.sv
// timecode_line_parser: top level of the serial timecode line parser
// input register, record scanner, result classification and output register
// depends on tcp_pkg and tcp_scan
//
// Usage:
//   Input channel: rx_byte and end_of_record move with in_valid/in_stall; one
//   beat per received byte. Bit 7 of rx_byte is ignored, bytes below space are
//   dropped, and a beat with end_of_record closes the record.
//   Output channel: one result beat (record_status and decoded fields) per
//   closed record that held at least one kept character, on out_valid/out_stall.
//   A closing byte is accepted into the input register, then passes through
//   the scanner into the output register, where its result beat is offered.
//   Throughput is one byte per cycle while no closing byte waits on a stalled
//   output; the scanner updates its accumulators in a single pass per byte.
//   Stall: when out_stall holds a waiting result, bytes that close no record
//   still move on; a closing byte waits in the input register, and in_stall
//   rises only then.
//   Reset (rst, synchronous) empties both registers, clears the record state
//   and sets the stored satellite code to none.
module timecode_line_parser import tcp_pkg::*; #(
  parameter int RECORD_LIMIT = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       end_of_record,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] record_status,
  output logic [9:0] day_of_year,
  output logic [6:0] hour_value,
  output logic [6:0] minute_value,
  output logic [6:0] second_value,
  output logic       not_in_sync,
  output logic [1:0] satellite_seen,
  output logic       request_resume
);

  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_last;
  logic             s1_go, s1_result, out_free, in_take;
  rec_t             rec;
  logic [1:0]       satellite_code, satellite_code_next;

  logic [2:0] status_next;
  logic [9:0] day_next;
  logic [6:0] hour_next, minute_next, second_next;
  logic       nis_next, resume_next;

  assign out_free  = !out_valid || !out_stall;
  assign s1_result = s1_last && rec.nonempty;
  assign s1_go     = s1_valid && (!s1_result || out_free);
  assign in_stall  = s1_valid && !s1_go;
  assign in_take   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= rx_byte[CharW-1:0];
      s1_last <= end_of_record;
    end
  end

  tcp_scan #(.RECORD_LIMIT(RECORD_LIMIT)) u_scan (
    .clk  (clk),
    .rst  (rst),
    .go   (s1_go),
    .ch   (s1_char),
    .last (s1_last),
    .rec  (rec)
  );

  // satellite code from the first two characters of a position record
  always_comb begin
    satellite_code_next = satellite_code;
    if (rec.pos_form) begin
      priority if (rec.first_ch == CH_ONE &&
                   (rec.second_ch == CH_THREE || rec.second_ch == CH_TWO)) begin
        satellite_code_next = SAT_WEST;
      end else if (rec.first_ch == CH_ONE && rec.second_ch == CH_ZERO) begin
        satellite_code_next = SAT_STANDBY;
      end else if (rec.first_ch == CH_ZERO && rec.second_ch == CH_SEVEN) begin
        satellite_code_next = SAT_EAST;
      end else begin
        satellite_code_next = SAT_NONE;
      end
    end
  end

  always_comb begin
    status_next = ST_BAD_REPLY;
    day_next    = '0;
    hour_next   = '0;
    minute_next = '0;
    second_next = '0;
    nis_next    = 1'b0;
    resume_next = 1'b0;
    if (rec.time_form) begin
      day_next    = rec.day;
      hour_next   = rec.hour;
      minute_next = rec.minute;
      second_next = rec.second;
      nis_next    = (rec.quality != CH_SPACE) && (rec.quality != CH_DOT) &&
                    (rec.quality != CH_STAR);
      priority if (rec.day < 10'd1 || rec.day > 10'(DayMax)) begin
        status_next = ST_BAD_DATE;
      end else if (rec.hour > 7'(HourMax) || rec.minute > 7'(MinSecMax) ||
                   rec.second > 7'(MinSecMax)) begin
        status_next = ST_BAD_TIME;
      end else begin
        status_next = ST_TIME_OK;
      end
    end else if (rec.pos_form) begin
      status_next = ST_POSITION;
      resume_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      satellite_code <= SAT_NONE;
    end else if (s1_go && s1_result) begin
      satellite_code <= satellite_code_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_result) begin
      record_status  <= status_next;
      day_of_year    <= day_next;
      hour_value     <= hour_next;
      minute_value   <= minute_next;
      second_value   <= second_next;
      not_in_sync    <= nis_next;
      satellite_seen <= satellite_code_next;
      request_resume <= resume_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_last && out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> record_status <= ST_BAD_TIME)
    else $error("record status out of range");

  a_resume_on_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_resume |-> record_status == ST_POSITION)
    else $error("resume request on a non-position record");

  a_bad_reply_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_status == ST_BAD_REPLY |->
      day_of_year == 10'd0 && hour_value == 7'd0 && not_in_sync == 1'b0 &&
      request_resume == 1'b0)
    else $error("bad reply carries decoded fields");

  a_sat_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(s1_go && s1_result) |=> !out_valid || satellite_seen == satellite_code)
    else $error("reported satellite code differs from stored code");

endmodule
